// ===== hw/rtl/dtm_pkg.sv =====
package dtm_pkg;

    // fixed field widths
    localparam int SYM_W    = 2;
    localparam int POS_W    = 12;
    localparam int ALPHABET = 4;

    typedef enum logic [1:0] {
        OP_PATTERN = 2'd0,
        OP_END     = 2'd1,
        OP_TEXT    = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_TRIE_FULL = 2'd1,
        STAT_TEXT_FULL = 2'd2,
        STAT_BEYOND    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAT_CHK,
        S_WALK_CHILD,
        S_WALK_CHK,
        S_WALK_END,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              matched;
        logic [POS_W-1:0]  echo_position;
        status_t           status;
    } result_t;

endpackage

// ===== hw/rtl/dtm_trie_mem.sv =====
module dtm_trie_mem #(
    parameter int MAX_NODES = 1024,
    localparam int NW = $clog2(MAX_NODES),
    localparam int CAW = NW + dtm_pkg::SYM_W
) (
    input  logic           aclk,
    input  logic           aresetn,
    output logic           clear_done,
    input  logic           child_rd_en,
    input  logic [CAW-1:0] child_rd_addr,
    output logic [NW-1:0]  child_rd_data,
    input  logic           child_wr_en,
    input  logic [CAW-1:0] child_wr_addr,
    input  logic [NW-1:0]  child_wr_data,
    input  logic           end_rd_en,
    input  logic [NW-1:0]  end_rd_addr,
    output logic           end_rd_data,
    input  logic           end_wr_en,
    input  logic [NW-1:0]  end_wr_addr
);
    import dtm_pkg::*;

    localparam int CDEPTH = MAX_NODES * ALPHABET;
    localparam logic [CAW-1:0] CLR_LAST = CAW'(CDEPTH - 1);

    logic [NW-1:0] child_mem [CDEPTH];
    logic          end_mem   [MAX_NODES];

    logic           clr_busy_reg;
    logic [CAW-1:0] clr_cnt_reg;

    // sweep both memories after reset, one child entry a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + CAW'(1);
            if (clr_cnt_reg == CLR_LAST) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign clear_done = !clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            child_mem[clr_cnt_reg] <= '0;
        end else if (child_wr_en) begin
            child_mem[child_wr_addr] <= child_wr_data;
        end
        if (child_rd_en) begin
            child_rd_data <= child_mem[child_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            end_mem[clr_cnt_reg[CAW-1:SYM_W]] <= 1'b0;
        end else if (end_wr_en) begin
            end_mem[end_wr_addr] <= 1'b1;
        end
        if (end_rd_en) begin
            end_rd_data <= end_mem[end_rd_addr];
        end
    end

endmodule

// ===== hw/rtl/dtm_seq.sv =====
module dtm_seq #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_TEXT = 4096,
    localparam int NW = $clog2(MAX_NODES),
    localparam int CAW = NW + dtm_pkg::SYM_W
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      clear_done,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  dtm_pkg::op_t              in_op,
    input  logic [dtm_pkg::SYM_W-1:0] in_sym,
    input  logic [dtm_pkg::POS_W-1:0] in_pos,
    output logic                      res_valid,
    input  logic                      res_ready,
    output dtm_pkg::result_t          res,
    output logic                      child_rd_en,
    output logic [CAW-1:0]            child_rd_addr,
    input  logic [NW-1:0]             child_rd_data,
    output logic                      child_wr_en,
    output logic [CAW-1:0]            child_wr_addr,
    output logic [NW-1:0]             child_wr_data,
    output logic                      end_rd_en,
    output logic [NW-1:0]             end_rd_addr,
    input  logic                      end_rd_data,
    output logic                      end_wr_en,
    output logic [NW-1:0]             end_wr_addr
);
    import dtm_pkg::*;

    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int TLW = $clog2(MAX_TEXT + 1);
    localparam int TAW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int PCW = (TLW > POS_W) ? TLW : POS_W;

    state_t state_reg, state_next;

    logic [NCW-1:0]   nodes_used_reg, nodes_used_next;
    logic [NW-1:0]    cursor_reg, cursor_next;
    logic [TLW-1:0]   len_reg, len_next;
    logic [NW-1:0]    node_reg, node_next;
    logic [TLW-1:0]   idx_reg, idx_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    result_t          res_reg, res_next;

    logic [SYM_W-1:0] text_mem [MAX_TEXT];
    logic             text_wr_en;
    logic             text_rd_en;
    logic [TAW-1:0]   text_rd_addr;
    logic [SYM_W-1:0] text_rd_data;

    logic           accept;
    logic           absent;
    logic           trie_full;
    logic           text_full;
    logic           beyond;
    logic           last_step;
    logic [PCW-1:0] pos_ext;
    logic [TLW-1:0] idx_plus;

    assign pos_ext   = PCW'(in_pos);
    assign idx_plus  = idx_reg + TLW'(1);
    assign absent    = (child_rd_data == '0);
    assign trie_full = (nodes_used_reg >= NCW'(MAX_NODES));
    assign text_full = (len_reg >= TLW'(MAX_TEXT));
    assign beyond    = (pos_ext >= PCW'(len_reg));
    assign last_step = (idx_plus == len_reg);
    assign in_ready  = clear_done && (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign res       = res_reg;

    always_ff @(posedge aclk) begin
        if (text_wr_en) begin
            text_mem[len_reg[TAW-1:0]] <= in_sym;
        end
        if (text_rd_en) begin
            text_rd_data <= text_mem[text_rd_addr];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_op == OP_PATTERN) begin
                        state_next = S_PAT_CHK;
                    end else if (in_op == OP_QUERY && !beyond) begin
                        state_next = S_WALK_CHILD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_PAT_CHK: state_next = S_DONE;
            S_WALK_CHILD: begin
                state_next = end_rd_data ? S_DONE : S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (absent) begin
                    state_next = S_DONE;
                end else if (last_step) begin
                    state_next = S_WALK_END;
                end else begin
                    state_next = S_WALK_CHILD;
                end
            end
            S_WALK_END: state_next = S_DONE;
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memory requests and handshake
    always_comb begin
        child_rd_en   = 1'b0;
        child_rd_addr = {cursor_reg, in_sym};
        child_wr_en   = 1'b0;
        child_wr_addr = {cursor_reg, sym_reg};
        child_wr_data = nodes_used_reg[NW-1:0];
        end_rd_en     = 1'b0;
        end_rd_addr   = '0;
        end_wr_en     = 1'b0;
        end_wr_addr   = cursor_reg;
        text_wr_en    = 1'b0;
        text_rd_en    = 1'b0;
        text_rd_addr  = pos_ext[TAW-1:0];
        res_valid     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_PATTERN: child_rd_en = 1'b1;
                        OP_END:     end_wr_en   = 1'b1;
                        OP_TEXT:    text_wr_en  = !text_full;
                        OP_QUERY: begin
                            text_rd_en = !beyond;
                            end_rd_en  = !beyond;
                        end
                        default: ;
                    endcase
                end
            end
            S_PAT_CHK: child_wr_en = absent && !trie_full;
            S_WALK_CHILD: begin
                child_rd_en   = !end_rd_data;
                child_rd_addr = {node_reg, text_rd_data};
            end
            S_WALK_CHK: begin
                end_rd_en    = !absent;
                end_rd_addr  = child_rd_data;
                text_rd_en   = !absent && !last_step;
                text_rd_addr = idx_plus[TAW-1:0];
            end
            S_DONE: res_valid = 1'b1;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        nodes_used_next = nodes_used_reg;
        cursor_next     = cursor_reg;
        len_next        = len_reg;
        node_next       = node_reg;
        idx_next        = idx_reg;
        sym_next        = sym_reg;
        res_next        = res_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    sym_next               = in_sym;
                    res_next.matched       = 1'b0;
                    res_next.echo_position = '0;
                    res_next.status        = STAT_OK;
                    case (in_op)
                        OP_END: cursor_next = '0;
                        OP_TEXT: begin
                            if (text_full) begin
                                res_next.status = STAT_TEXT_FULL;
                            end else begin
                                len_next = len_reg + TLW'(1);
                            end
                        end
                        OP_QUERY: begin
                            res_next.echo_position = in_pos;
                            if (beyond) begin
                                res_next.status = STAT_BEYOND;
                            end else begin
                                node_next = '0;
                                idx_next  = pos_ext[TLW-1:0];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PAT_CHK: begin
                if (!absent) begin
                    cursor_next = child_rd_data;
                end else if (trie_full) begin
                    res_next.status = STAT_TRIE_FULL;
                end else begin
                    cursor_next     = nodes_used_reg[NW-1:0];
                    nodes_used_next = nodes_used_reg + NCW'(1);
                end
            end
            S_WALK_CHILD: res_next.matched = end_rd_data;
            S_WALK_CHK: begin
                if (!absent) begin
                    node_next = child_rd_data;
                    idx_next  = idx_plus;
                end
            end
            S_WALK_END: res_next.matched = end_rd_data;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            nodes_used_reg <= NCW'(1);
            cursor_reg     <= '0;
            len_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            nodes_used_reg <= nodes_used_next;
            cursor_reg     <= cursor_next;
            len_reg        <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg <= node_next;
        idx_reg  <= idx_next;
        sym_reg  <= sym_next;
        res_reg  <= res_next;
    end

endmodule

// ===== hw/rtl/dna_trie_multi_pattern_match.sv =====
// flow: end, text and past-end query items go from the idle state straight to the done state,
// pattern symbols pass a check state first; a query alternates child-read and check states
// level by level until a missing child, a pattern end or the end of the text stops it
// one item at a time, next input transfer in the cycle after the result is registered
// reset: synchronous active-low; afterwards a sweep clears the child table and end marks,
// s_tready stays low until it finishes
module dna_trie_multi_pattern_match #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_TEXT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // symbol[1:0], start_position[13:2], zero pad
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // matched[0], echo_position[12:1], status[14:13], zero pad
);
    import dtm_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int CAW = NW + SYM_W;

    // trie memory hookup
    logic           clear_done;
    logic           child_rd_en;
    logic [CAW-1:0] child_rd_addr;
    logic [NW-1:0]  child_rd_data;
    logic           child_wr_en;
    logic [CAW-1:0] child_wr_addr;
    logic [NW-1:0]  child_wr_data;
    logic           end_rd_en;
    logic [NW-1:0]  end_rd_addr;
    logic           end_rd_data;
    logic           end_wr_en;
    logic [NW-1:0]  end_wr_addr;

    // sequencer result handoff
    logic    res_valid;
    logic    res_ready;
    result_t res;

    // output register parts the sequencer from the result channel
    logic    m_valid_reg;
    result_t m_res_reg;

    dtm_trie_mem #(
        .MAX_NODES(MAX_NODES)
    ) u_trie_mem (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .clear_done   (clear_done),
        .child_rd_en  (child_rd_en),
        .child_rd_addr(child_rd_addr),
        .child_rd_data(child_rd_data),
        .child_wr_en  (child_wr_en),
        .child_wr_addr(child_wr_addr),
        .child_wr_data(child_wr_data),
        .end_rd_en    (end_rd_en),
        .end_rd_addr  (end_rd_addr),
        .end_rd_data  (end_rd_data),
        .end_wr_en    (end_wr_en),
        .end_wr_addr  (end_wr_addr)
    );

    dtm_seq #(
        .MAX_NODES(MAX_NODES),
        .MAX_TEXT (MAX_TEXT)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .clear_done   (clear_done),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (op_t'(s_tuser[1:0])),
        .in_sym       (s_tdata[1:0]),
        .in_pos       (s_tdata[13:2]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .child_rd_en  (child_rd_en),
        .child_rd_addr(child_rd_addr),
        .child_rd_data(child_rd_data),
        .child_wr_en  (child_wr_en),
        .child_wr_addr(child_wr_addr),
        .child_wr_data(child_wr_data),
        .end_rd_en    (end_rd_en),
        .end_rd_addr  (end_rd_addr),
        .end_rd_data  (end_rd_data),
        .end_wr_en    (end_wr_en),
        .end_wr_addr  (end_wr_addr)
    );

    // result register is free when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg.status, m_res_reg.echo_position, m_res_reg.matched};

`ifndef SYNTHESIS
    // no transfer accepted while the clearing sweep runs
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> clear_done)
        else $error("input accepted during clearing sweep");

    // a query past the text never reports a match
    a_beyond_unmatched: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[14:13] == STAT_BEYOND) |-> !m_tdata[0])
        else $error("match reported for position beyond text");

    // a match only comes with ok status
    a_match_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[14:13] == STAT_OK))
        else $error("match reported with error status");

    // sequencer never offers a result while it also takes a new item
    a_seq_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_tready)
        else $error("sequencer ready while result pending");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import dtm_pkg::*;

    localparam int NODE_CAP         = 1024;
    localparam int TEXT_CAP         = 4096;
    localparam int RANDOM_ITEMS     = 1310;
    localparam int QUIET_ITEMS      = 150;      // closing stretch of the random part, no idling
    localparam int LONG_HOLD_AT     = 300;      // results seen before the long receiver hold
    localparam int LONG_HOLD_CYCLES = 250;
    localparam int DRAIN_CYCLES     = 64;       // idle stretch after the last result has been checked
    localparam int unsigned RUN_LIMIT = 2_000_000;

    // nucleotide codes
    localparam logic [1:0] NT_A = 2'd0;
    localparam logic [1:0] NT_C = 2'd1;
    localparam logic [1:0] NT_G = 2'd2;
    localparam logic [1:0] NT_T = 2'd3;

    // trie and text mirror plus the queue of answers still owed by the block
    class trie_match_board #(int NODE_CAP = 1024, int TEXT_CAP = 4096);
        localparam logic [10:0] NO_CHILD = 11'd0;
        localparam int unsigned ROOT_NODE = 0;

        logic [10:0] kids [NODE_CAP*ALPHABET];
        bit          ends [NODE_CAP];
        logic [1:0]  text_syms [TEXT_CAP];
        int unsigned node_count;
        int unsigned cursor_node;
        int unsigned text_len;
        result_t     pending_answers [$];
        int          errors;
        int          query_count;
        int          match_count;
        int          beyond_count;
        int          trie_full_count;
        int          text_full_count;

        function new();
            foreach (kids[i]) kids[i] = NO_CHILD;
            foreach (ends[i]) ends[i] = 1'b0;
            foreach (text_syms[i]) text_syms[i] = NT_A;
            node_count      = 1;
            cursor_node     = ROOT_NODE;
            text_len        = 0;
            errors          = 0;
            query_count     = 0;
            match_count     = 0;
            beyond_count    = 0;
            trie_full_count = 0;
            text_full_count = 0;
        endfunction

        // follow the text from a start index down the trie, stop at the first pattern end
        function bit walk_hits(int unsigned first);
            int unsigned node;
            int unsigned i;
            logic [10:0] nxt;
            node = ROOT_NODE;
            for (i = first; i < text_len; i++) begin
                if (ends[node]) return 1'b1;
                nxt = kids[node*ALPHABET + text_syms[i]];
                if (nxt == NO_CHILD) return 1'b0;
                node = 32'(nxt);
            end
            return ends[node];
        endfunction

        // accepted input transfer: update the mirror and queue the answer it causes
        function void note_item(op_t op, logic [1:0] sym, logic [11:0] pos);
            result_t     ans;
            int unsigned slot;
            ans.matched       = 1'b0;
            ans.echo_position = '0;
            ans.status        = STAT_OK;
            case (op)
                OP_PATTERN: begin
                    slot = cursor_node*ALPHABET + sym;
                    if (kids[slot] != NO_CHILD) begin
                        cursor_node = 32'(kids[slot]);
                    end else if (node_count >= NODE_CAP) begin
                        ans.status = STAT_TRIE_FULL;
                        trie_full_count++;
                    end else begin
                        kids[slot]  = 11'(node_count);
                        cursor_node = node_count;
                        node_count++;
                    end
                end
                OP_END: begin
                    ends[cursor_node] = 1'b1;
                    cursor_node       = ROOT_NODE;
                end
                OP_TEXT: begin
                    if (text_len >= TEXT_CAP) begin
                        ans.status = STAT_TEXT_FULL;
                        text_full_count++;
                    end else begin
                        text_syms[text_len] = sym;
                        text_len++;
                    end
                end
                default: begin
                    query_count++;
                    ans.echo_position = pos;
                    if (pos >= text_len) begin
                        ans.status = STAT_BEYOND;
                        beyond_count++;
                    end else begin
                        ans.matched = walk_hits(32'(pos));
                        if (ans.matched) match_count++;
                    end
                end
            endcase
            pending_answers.insert(pending_answers.size(), ans);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) $display("[%0t] %s", $time, what);
        endtask

        // m_tdata: matched[0], echo_position[12:1], status[14:13]
        task check_result(logic [15:0] word);
            result_t want;
            if (pending_answers.size() == 0) begin
                report($sformatf("result %h arrived with no answer pending", word));
                return;
            end
            want = pending_answers.pop_front();
            if (word[0] !== want.matched)
                report($sformatf("matched %b, wanted %b (position %0d)",
                                 word[0], want.matched, want.echo_position));
            if (word[12:1] !== want.echo_position)
                report($sformatf("echo_position %0d, wanted %0d",
                                 word[12:1], want.echo_position));
            if (word[14:13] !== want.status)
                report($sformatf("status %0d, wanted %0d (position %0d)",
                                 word[14:13], want.status, want.echo_position));
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // symbol[1:0], start_position[13:2], zero pad
    logic [1:0]  s_tuser  = OP_PATTERN;  // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // matched[0], echo_position[12:1], status[14:13]

    trie_match_board #(NODE_CAP, TEXT_CAP) sb;

    bit          no_idle = 1'b0;    // both sides skip their idle bursts while set
    int          items_sent = 0;
    int unsigned cycle_count = 0;

    always #1 aclk = ~aclk;

    dna_trie_multi_pattern_match #(
        .MAX_NODES(NODE_CAP),
        .MAX_TEXT (TEXT_CAP)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // one input transfer; fields the operation ignores carry random bits
    task automatic send_item(input op_t op, input logic [1:0] sym, input logic [11:0] pos);
        logic [1:0]  sym_bits;
        logic [11:0] pos_bits;
        sym_bits = (op == OP_END || op == OP_QUERY) ? 2'($urandom) : sym;
        pos_bits = (op == OP_QUERY) ? pos : 12'($urandom);
        // sender idle burst, valid dropped in between
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, pos_bits, sym_bits};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_item(op, sym_bits, pos_bits);
        items_sent++;
    endtask

    // pattern symbols from the low bits up, closed by an end-of-pattern
    task automatic insert_motif(input logic [31:0] bits, input int len);
        int i;
        for (i = 0; i < len; i++) send_item(OP_PATTERN, bits[2*i +: 2], 12'd0);
        send_item(OP_END, NT_A, 12'd0);
    endtask

    task automatic append_text(input logic [31:0] bits, input int len);
        int i;
        for (i = 0; i < len; i++) send_item(OP_TEXT, bits[2*i +: 2], 12'd0);
    endtask

    // mostly a start index inside the stored text, now and then any 12-bit value
    function automatic logic [11:0] pick_position();
        if (sb.text_len == 0 || $urandom_range(0, 9) == 0) return 12'($urandom);
        return 12'($urandom_range(0, sb.text_len - 1));
    endfunction

    // receiver: checks each result transfer, stalls in bursts and holds off once for long
    int answers_seen   = 0;
    int stall_left     = 0;
    bit long_hold_done = 1'b0;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            sb.check_result(m_tdata);
            answers_seen++;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && answers_seen == LONG_HOLD_AT) begin
            // the sender keeps offering while this lasts, so the block backs up its input
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("dna_trie_multi_pattern_match: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0] motif_bits [$];
        int          motif_lens [$];
        logic [31:0] bits;
        int          r;
        int          len;
        int          k;
        int          copy_start;
        int          random_start;

        sb = new();
        copy_start = -1;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: queries on empty text, lowest and highest position
        send_item(OP_QUERY, NT_A, 12'd0);
        send_item(OP_QUERY, NT_A, 12'd4095);
        // patterns ACG and ACT share the AC prefix, T takes a new branch
        insert_motif({NT_G, NT_C, NT_A}, 3);
        insert_motif({NT_T, NT_C, NT_A}, 3);
        // text TACGAC
        append_text({NT_C, NT_A, NT_G, NT_C, NT_A, NT_T}, 6);
        send_item(OP_QUERY, NT_A, 12'd0);   // T has no child at the root
        send_item(OP_QUERY, NT_A, 12'd1);   // ACG hits a pattern end
        send_item(OP_QUERY, NT_A, 12'd4);   // text runs out on AC, not an end
        send_item(OP_QUERY, NT_A, 12'd6);   // first index past the text
        send_item(OP_QUERY, NT_A, 12'd5);   // C has no child at the root

        // random sequences: well-formed patterns, text runs, pattern copies in the text,
        // queries; unterminated pattern runs as noise. a stray end at the root would
        // mark the empty pattern, so that is kept for the end of the run
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (items_sent - random_start >= RANDOM_ITEMS - QUIET_ITEMS) no_idle = 1'b1;
            else if ((items_sent % 150) == 0) no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 25) begin
                len  = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2)
                                                    : $urandom_range(3, 7);
                bits = $urandom;
                insert_motif(bits, len);
                motif_bits.insert(motif_bits.size(), bits);
                motif_lens.insert(motif_lens.size(), len);
            end else if (r < 30) begin
                append_text(32'd0, 0);
                for (k = 0; k < $urandom_range(1, 3); k++)
                    send_item(OP_PATTERN, 2'($urandom), 12'd0);
            end else if (r < 55) begin
                append_text($urandom, $urandom_range(1, 8));
            end else if (r < 65 && motif_lens.size() != 0) begin
                k    = $urandom_range(0, motif_lens.size() - 1);
                bits = motif_bits[k];
                if ($urandom_range(0, 2) == 0)
                    bits[2*$urandom_range(0, motif_lens[k] - 1) +: 2] = 2'($urandom);
                copy_start = sb.text_len;
                append_text(bits, motif_lens[k]);
            end else if (r < 95) begin
                if (copy_start >= 0 && copy_start < sb.text_len && $urandom_range(0, 2) == 0)
                    send_item(OP_QUERY, NT_A, 12'(copy_start));
                else
                    send_item(OP_QUERY, NT_A, pick_position());
            end else begin
                // last stored index or the first one past it
                send_item(OP_QUERY, NT_A, 12'(sb.text_len - $urandom_range(0, 1)));
            end
        end

        // a few more text symbols, then the extreme and middle positions
        repeat (3) send_item(OP_TEXT, 2'($urandom), 12'd0);
        send_item(OP_QUERY, NT_A, 12'd4095);
        send_item(OP_QUERY, NT_A, 12'd0);
        send_item(OP_QUERY, NT_A, 12'd2048);

        // empty pattern: after an end at the root every valid position matches
        no_idle = 1'b1;
        while (sb.cursor_node != 0) send_item(OP_END, NT_A, 12'd0);
        send_item(OP_END, NT_A, 12'd0);
        send_item(OP_QUERY, NT_A, 12'd0);
        send_item(OP_QUERY, NT_A, 12'd4095);
        repeat (4) send_item(OP_QUERY, NT_A, pick_position());
        send_item(OP_PATTERN, 2'($urandom), 12'd0);
        send_item(OP_TEXT, 2'($urandom), 12'd0);
        send_item(OP_QUERY, NT_A, pick_position());
        s_tvalid <= 1'b0;

        while (sb.pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d transfers: %0d queries, %0d matched, %0d past the text end",
                 items_sent, sb.query_count, sb.match_count, sb.beyond_count);
        $display("trie filled to %0d nodes (%0d dropped symbols), text to %0d (%0d dropped)",
                 sb.node_count, sb.trie_full_count, sb.text_len, sb.text_full_count);
        if (sb.errors == 0) begin
            $display("dna_trie_multi_pattern_match: match");
        end else begin
            $display("dna_trie_multi_pattern_match: mismatch");
        end
        $finish;
    end

endmodule

// ===== dna_trie_multi_pattern_match.f =====
hw/rtl/dtm_pkg.sv
hw/rtl/dtm_trie_mem.sv
hw/rtl/dtm_seq.sv
hw/rtl/dna_trie_multi_pattern_match.sv
verif/tb.sv
